// ===== hdl/mktc_pkg.sv =====
package mktc_pkg;

  // Widths fixed by the field definitions
  localparam int unsigned THR_BITS        = 16;
  localparam int unsigned EDGE_BITS       = 2;
  localparam int unsigned EVENT_BITS      = 3;
  localparam int unsigned CFG_INDEX_BITS  = 2;
  localparam int unsigned DEF_COUNT_BITS  = 16;

  // Key edge codes
  localparam logic [EDGE_BITS-1:0] EDGE_NONE    = 2'd0;
  localparam logic [EDGE_BITS-1:0] EDGE_PRESS   = 2'd1;
  localparam logic [EDGE_BITS-1:0] EDGE_RELEASE = 2'd2;

  // Symbol event codes
  localparam logic [EVENT_BITS-1:0] EV_NONE   = 3'd0;
  localparam logic [EVENT_BITS-1:0] EV_DOT    = 3'd1;
  localparam logic [EVENT_BITS-1:0] EV_DASH   = 3'd2;
  localparam logic [EVENT_BITS-1:0] EV_LETTER = 3'd3;
  localparam logic [EVENT_BITS-1:0] EV_WORD   = 3'd4;

  // Threshold register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_DASH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LETTER = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WORD   = 2'd2;

  // Threshold reset values
  localparam logic [THR_BITS-1:0] DASH_RESET   = 16'd50;
  localparam logic [THR_BITS-1:0] LETTER_RESET = 16'd50;
  localparam logic [THR_BITS-1:0] WORD_RESET   = 16'd100;

  typedef struct packed {
    logic [THR_BITS-1:0] dash_ticks;
    logic [THR_BITS-1:0] letter_gap_ticks;
    logic [THR_BITS-1:0] word_gap_ticks;
  } thresh_t;

endpackage

// ===== hdl/mktc_classify.sv =====
module mktc_classify #(
  parameter int unsigned COUNT_BITS = mktc_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [mktc_pkg::EDGE_BITS-1:0]   key_edge,
  input  mktc_pkg::thresh_t                thresh,
  output logic [mktc_pkg::EVENT_BITS-1:0]  symbol_event
);
  import mktc_pkg::*;

  localparam int unsigned CMP_BITS = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

  typedef enum logic [3:0] {
    PH_WAITING = 4'b0001,
    PH_DOT     = 4'b0010,
    PH_DASH    = 4'b0100,
    PH_GAP     = 4'b1000
  } phase_t;

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CMP_BITS-1:0]   count_cmp;
  logic                  dash_hit, letter_hit, word_hit;

  // Saturating increment, then compare at a common width
  assign count_inc  = (&tick_count) ? tick_count : tick_count + 1'b1;
  assign count_cmp  = CMP_BITS'(count_inc);
  assign dash_hit   = count_cmp >= CMP_BITS'(thresh.dash_ticks);
  assign letter_hit = count_cmp >= CMP_BITS'(thresh.letter_gap_ticks);
  assign word_hit   = count_cmp >= CMP_BITS'(thresh.word_gap_ticks);

  // Phase update for one tick
  always_comb begin
    phase_next      = phase;
    tick_count_next = count_inc;
    symbol_event    = EV_NONE;
    case (phase)
      PH_WAITING: begin
        if (key_edge == EDGE_PRESS) begin
          phase_next      = PH_DOT;
          tick_count_next = '0;
        end
      end
      PH_DOT: begin
        if (dash_hit) phase_next = PH_DASH;
        // a release still yields dot on the tick the dash threshold is met
        if (key_edge == EDGE_RELEASE) begin
          phase_next      = PH_GAP;
          tick_count_next = '0;
          symbol_event    = EV_DOT;
        end
      end
      PH_DASH: begin
        if (key_edge == EDGE_RELEASE) begin
          phase_next      = PH_GAP;
          tick_count_next = '0;
          symbol_event    = EV_DASH;
        end
      end
      PH_GAP: begin
        if (word_hit) begin
          phase_next      = PH_WAITING;
          tick_count_next = '0;
          symbol_event    = EV_WORD;
        end else if (key_edge == EDGE_PRESS) begin
          phase_next      = PH_DOT;
          tick_count_next = '0;
          if (letter_hit) symbol_event = EV_LETTER;
        end
      end
      default: begin
        phase_next      = PH_WAITING;
        tick_count_next = '0;
      end
    endcase
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAITING;
      tick_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

  a_wait_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_WAITING |-> symbol_event == EV_NONE)
    else $error("event emitted while waiting");

  a_word_idles: assert property (@(posedge clk) disable iff (rst)
    accept && symbol_event == EV_WORD |=> phase == PH_WAITING && tick_count == '0)
    else $error("inter-word did not return to waiting");

  a_mark_gap: assert property (@(posedge clk) disable iff (rst)
    accept && (symbol_event == EV_DOT || symbol_event == EV_DASH)
    |=> phase == PH_GAP && tick_count == '0)
    else $error("dot or dash did not enter gap");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(tick_count))
    else $error("state moved without a tick");

endmodule

// ===== hdl/mktc_out_buf.sv =====
module mktc_out_buf (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [mktc_pkg::EVENT_BITS-1:0]  push_data,
  output logic                             space,
  output logic                             valid,
  input  logic                             pop,
  output logic [mktc_pkg::EVENT_BITS-1:0]  head_data
);
  import mktc_pkg::*;

  logic [1:0]            fill;
  logic [EVENT_BITS-1:0] word0, word1;

  assign space     = (fill != 2'd2);
  assign valid     = (fill != 2'd0);
  assign head_data = word0;

  // Hold up to two words; the second entry acts as the skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (fill == 2'd0) word0 <= push_data;
        else              word1 <= push_data;
      end
      2'b01: begin
        word0 <= word1;
      end
      2'b11: begin
        if (fill == 2'd2) begin
          word0 <= word1;
          word1 <= push_data;
        end else begin
          word0 <= push_data;
        end
      end
      default: begin
        word0 <= word0;
      end
    endcase
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("buffer fill out of range");

  a_first_word: assert property (@(posedge clk) disable iff (rst)
    push && !pop && fill == 2'd0 |=> valid && head_data == $past(push_data))
    else $error("first word not presented");

endmodule

// ===== hdl/morse_key_timing_classifier.sv =====
// Morse key timing classifier.
// Input stream (s_*): one word per timer tick carrying the key edge of that
// tick (none, pressed, released). Output stream (m_*): exactly one word per
// input word carrying the symbol event (none, dot, dash, inter-letter,
// inter-word), in input order.
// The phase machine and saturating tick counter update in the cycle a word
// is accepted; its result is registered in the output buffer and presented
// on m_tdata from there. One word is taken every cycle while the output side
// keeps up, set by the single compare-and-increment update of the phase machine.
// A two-word output buffer sits between the sides: the block keeps taking
// input while one result waits, and drops s_tready only when two results
// are held because the receiver stalls.
// The cfg_* port writes the dash, letter-gap and word-gap thresholds
// (index 0, 1, 2); write only while the block is idle.
// Reset (rst, synchronous) returns the machine to waiting, clears the tick
// counter and the output buffer, and restores thresholds 50, 50 and 100.
module morse_key_timing_classifier #(
  parameter int unsigned COUNT_BITS = mktc_pkg::DEF_COUNT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [1:0] key_edge
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [7:0]                           m_tdata,   // [2:0] symbol_event
  input  logic                                 cfg_we,
  input  logic [mktc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mktc_pkg::THR_BITS-1:0]        cfg_data
);
  import mktc_pkg::*;

  thresh_t               thresh;
  logic                  accept;
  logic                  buf_space;
  logic [EVENT_BITS-1:0] event_in, event_out;

  assign s_tready = buf_space;
  assign accept   = s_tvalid && buf_space;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.dash_ticks       <= DASH_RESET;
      thresh.letter_gap_ticks <= LETTER_RESET;
      thresh.word_gap_ticks   <= WORD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DASH:   thresh.dash_ticks       <= cfg_data;
        REG_LETTER: thresh.letter_gap_ticks <= cfg_data;
        REG_WORD:   thresh.word_gap_ticks   <= cfg_data;
        default:    thresh                  <= thresh;
      endcase
    end
  end

  mktc_classify #(
    .COUNT_BITS (COUNT_BITS)
  ) u_classify (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .key_edge     (s_tdata[EDGE_BITS-1:0]),
    .thresh       (thresh),
    .symbol_event (event_in)
  );

  mktc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (event_in),
    .space     (buf_space),
    .valid     (m_tvalid),
    .pop       (m_tvalid && m_tready),
    .head_data (event_out)
  );

  assign m_tdata = {(8 - EVENT_BITS)'(0), event_out};

endmodule
